FILE: rtl/md5_pkg.sv
package md5_pkg;

    // Channel payloads
    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        is_last;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_low;
        logic [63:0] digest_high;
    } out_item_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LENHI,
        ST_ROUND,
        ST_FINAL
    } md5_state_t;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [31:0] SINE_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROT_TAB [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

endpackage

FILE: rtl/md5_stream_hasher_top.sv
// Streaming MD5 hasher. Message words arrive little-endian on s_data with a byte count
// and a last mark; the digest (A,B in digest_low, C,D in digest_high) appears on m_data
// once per message, after which the hash state is back at its initial values. Words are
// written into the block one per cycle while the back end is idle, so a 16-word block
// is loaded, then run through the single round unit, and then the chaining add is made.
// The last block adds the pad words, written one at a time, and the upper length word;
// when 56 or more bytes remain in it, one extra block of pad words follows. A two-entry
// queue sits before the back end, and the digest waits in an output register; the back
// end holds in its final cycle while an earlier digest has not been taken.
module md5_stream_hasher_top
    import md5_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic     q_valid;
    logic     q_ready;
    in_item_t q_item;

    md5_in_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    md5_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/md5_in_queue.sv
module md5_in_queue
    import md5_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     q_valid,
    input  logic     q_ready,
    output in_item_t q_item
);

    // Two-entry queue between the input port and the back end
    in_item_t   slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    in_item_t   item_in;

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Classify: words before the last, and oversize counts, carry 4 bytes
    always_comb begin
        item_in = s_data;
        if (!s_data.is_last || s_data.byte_count > 3'd4) begin
            item_in.byte_count = 3'd4;
        end
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

FILE: rtl/md5_back.sv
module md5_back
    import md5_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_valid,
    output logic      q_ready,
    input  in_item_t  q_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    md5_state_t  state_reg, state_next;
    logic [31:0] blk_reg [16];
    logic [3:0]  widx_reg, widx_next;
    logic [60:0] msg_reg, msg_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] a_next, b_next, c_next, d_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        pend80_reg, pend80_next;
    logic        pad_reg, pad_next;
    logic        final_reg, final_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;

    logic        blk_we;
    logic [31:0] blk_wdata;
    logic        out_free;
    logic [63:0] len_bits;
    logic [31:0] last_word;
    logic [60:0] msg_sum;

    // Round datapath
    logic [31:0] f_val, t_val, rot_val;
    logic [3:0]  g_idx;
    logic [4:0]  s_amt;
    logic [63:0] rot_wide;

    assign q_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign msg_sum  = msg_reg + {58'd0, q_item.byte_count};
    assign len_bits = {msg_reg, 3'b000};

    // Last word: keep valid bytes, put the pad byte right after them
    always_comb begin
        case (q_item.byte_count)
            3'd0:    last_word = {24'd0, PAD_BYTE};
            3'd1:    last_word = {16'd0, PAD_BYTE, q_item.data_word[7:0]};
            3'd2:    last_word = {8'd0, PAD_BYTE, q_item.data_word[15:0]};
            3'd3:    last_word = {PAD_BYTE, q_item.data_word[23:0]};
            default: last_word = q_item.data_word;
        endcase
    end

    // One MD5 round
    always_comb begin
        case (rnd_reg[5:4])
            2'd0: begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                g_idx = rnd_reg[3:0];
            end
            2'd1: begin
                f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
                g_idx = {rnd_reg[1:0], 2'b00} + rnd_reg[3:0] + 4'd1;
            end
            2'd2: begin
                f_val = b_reg ^ c_reg ^ d_reg;
                g_idx = {rnd_reg[2:0], 1'b0} + rnd_reg[3:0] + 4'd5;
            end
            default: begin
                f_val = c_reg ^ (b_reg | ~d_reg);
                g_idx = {rnd_reg[0], 3'b000} - rnd_reg[3:0];
            end
        endcase
        s_amt    = ROT_TAB[{rnd_reg[5:4], rnd_reg[1:0]}];
        t_val    = a_reg + f_val + blk_reg[g_idx] + SINE_TAB[rnd_reg];
        rot_wide = {t_val, t_val} << s_amt;
        rot_val  = rot_wide[63:32];
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (widx_reg == 4'd15) begin
                        state_next = ST_ROUND;
                    end else if (q_item.is_last) begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (widx_reg == 4'd14 && !pend80_reg) begin
                    state_next = ST_LENHI;
                end else if (widx_reg == 4'd15) begin
                    state_next = ST_ROUND;
                end
            end
            ST_LENHI: state_next = ST_ROUND;
            ST_ROUND: begin
                if (rnd_reg == 6'd63) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                if (final_reg) begin
                    if (out_free) begin
                        state_next = ST_IDLE;
                    end
                end else if (pad_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and register updates per state
    always_comb begin
        widx_next    = widx_reg;
        msg_next     = msg_reg;
        chain_next   = chain_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        c_next       = c_reg;
        d_next       = d_reg;
        rnd_next     = rnd_reg;
        pend80_next  = pend80_reg;
        pad_next     = pad_reg;
        final_next   = final_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        blk_we       = 1'b0;
        blk_wdata    = q_item.data_word;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    blk_we    = 1'b1;
                    blk_wdata = q_item.is_last ? last_word : q_item.data_word;
                    widx_next = widx_reg + 4'd1;
                    msg_next  = msg_sum;
                    if (q_item.is_last) begin
                        pad_next    = 1'b1;
                        pend80_next = (q_item.byte_count == 3'd4);
                    end
                end
            end
            ST_PAD: begin
                blk_we    = 1'b1;
                widx_next = widx_reg + 4'd1;
                if (widx_reg == 4'd14 && !pend80_reg) begin
                    blk_wdata = len_bits[31:0];
                end else begin
                    blk_wdata   = pend80_reg ? {24'd0, PAD_BYTE} : 32'd0;
                    pend80_next = 1'b0;
                end
            end
            ST_LENHI: begin
                blk_we     = 1'b1;
                blk_wdata  = len_bits[63:32];
                widx_next  = widx_reg + 4'd1;
                final_next = 1'b1;
            end
            ST_ROUND: begin
                a_next   = d_reg;
                d_next   = c_reg;
                c_next   = b_reg;
                b_next   = b_reg + rot_val;
                rnd_next = rnd_reg + 6'd1;
            end
            ST_FINAL: begin
                chain_next[0] = chain_reg[0] + a_reg;
                chain_next[1] = chain_reg[1] + b_reg;
                chain_next[2] = chain_reg[2] + c_reg;
                chain_next[3] = chain_reg[3] + d_reg;
                if (final_reg) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_data_next.digest_low  = {chain_next[1], chain_next[0]};
                        m_data_next.digest_high = {chain_next[3], chain_next[2]};
                        chain_next[0] = IV_A;
                        chain_next[1] = IV_B;
                        chain_next[2] = IV_C;
                        chain_next[3] = IV_D;
                        msg_next      = 61'd0;
                        widx_next     = 4'd0;
                        pad_next      = 1'b0;
                        final_next    = 1'b0;
                        pend80_next   = 1'b0;
                    end else begin
                        chain_next = chain_reg;
                    end
                end
            end
            default: ;
        endcase
        // Load working words from the chain at the start of a block
        if (state_reg != ST_ROUND && state_next == ST_ROUND) begin
            a_next   = chain_reg[0];
            b_next   = chain_reg[1];
            c_next   = chain_reg[2];
            d_next   = chain_reg[3];
            rnd_next = 6'd0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            widx_reg    <= 4'd0;
            msg_reg     <= 61'd0;
            chain_reg   <= '{IV_A, IV_B, IV_C, IV_D};
            rnd_reg     <= 6'd0;
            pend80_reg  <= 1'b0;
            pad_reg     <= 1'b0;
            final_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            widx_reg    <= widx_next;
            msg_reg     <= msg_next;
            chain_reg   <= chain_next;
            rnd_reg     <= rnd_next;
            pend80_reg  <= pend80_next;
            pad_reg     <= pad_next;
            final_reg   <= final_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        a_reg      <= a_next;
        b_reg      <= b_next;
        c_reg      <= c_next;
        d_reg      <= d_next;
        m_data_reg <= m_data_next;
        if (blk_we) begin
            blk_reg[widx_reg] <= blk_wdata;
        end
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import md5_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_LEN = 2000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    md5_stream_hasher_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Predictor state
    logic [31:0] chain_q [4];
    logic [31:0] blk_q [16];
    int unsigned fill_q;
    logic [60:0] msg_len_q;
    out_item_t   digest_q [$];

    int  error_count = 0;
    bit  quiet_mode = 0;    // long stretch without random idling
    bit  rx_hold = 0;       // receiver hold-off
    int  idle_cycles = 0;
    bit  timed_out = 0;

    // Clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    function automatic logic [31:0] rotl(logic [31:0] x, int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // One 64-round compression of the held block into the chaining value
    function automatic void compress_block();
        logic [31:0] a, b, c, d, f, t;
        logic [31:0] sine [64];
        int unsigned rots [16];
        int unsigned g;
        sine = '{
            32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
            32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
            32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
            32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
            32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
            32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
            32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
            32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
            32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
            32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
            32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
            32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
            32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
            32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
            32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
            32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
        rots = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
        for (int i = 0; i < 64; i++) begin
            case (i / 16)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
                2: begin f = b ^ c ^ d;          g = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
            endcase
            t = a + f + blk_q[g] + sine[i];
            t = rotl(t, rots[(i / 16) * 4 + i % 4]);
            a = d; d = c; c = b; b = b + t;
        end
        chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
    endfunction

    function automatic void append_byte(logic [7:0] v);
        int unsigned w, sh;
        w = fill_q / 4;
        sh = (fill_q % 4) * 8;
        if (sh == 0) blk_q[w] = {24'h0, v};
        else blk_q[w] |= {24'h0, v} << sh;
        fill_q = (fill_q + 1) % 64;
        if (fill_q == 0) compress_block();
    endfunction

    function automatic void init_hash();
        chain_q = '{IV_A, IV_B, IV_C, IV_D};
        fill_q = 0;
        msg_len_q = '0;
    endfunction

    // Expected digest for each accepted item that closes a message
    function automatic void predict_word(in_item_t it);
        int unsigned n;
        logic [63:0] bits;
        out_item_t r;
        n = (!it.is_last || it.byte_count > 4) ? 4 : it.byte_count;
        for (int i = 0; i < n; i++) append_byte(it.data_word[8*i +: 8]);
        msg_len_q = msg_len_q + 61'(n);
        if (!it.is_last) return;
        append_byte(PAD_BYTE);
        while (fill_q != 56) append_byte(8'h00);
        bits = {msg_len_q, 3'b000};
        for (int i = 0; i < 8; i++) append_byte(bits[8*i +: 8]);
        r.digest_low  = {chain_q[1], chain_q[0]};
        r.digest_high = {chain_q[3], chain_q[2]};
        digest_q.push_back(r);
        init_hash();
    endfunction

    // Send one item; predict on acceptance. Valid stays up for a following item.
    task automatic send_word(logic [31:0] w, logic [2:0] n, logic l);
        while (!quiet_mode && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{data_word: w, byte_count: n, is_last: l};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_word('{data_word: w, byte_count: n, is_last: l});
    endtask

    // Message of len_words full words and a last word with byte count tail
    task automatic send_message(int len_words, logic [2:0] tail);
        for (int i = 0; i < len_words; i++)
            send_word($urandom, 3'($urandom_range(7)), 1'b0);
        send_word($urandom, tail, 1'b1);
    endtask

    // Receiver ready, with random idling and a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 9);
        end
    end

    // Result check against the oldest expected digest
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (digest_q.size() == 0) begin
                $error("digest with nothing expected: %h", m_data);
                error_count++;
            end else begin
                out_item_t e;
                e = digest_q.pop_front();
                if (m_data.digest_low !== e.digest_low) begin
                    $error("digest_low expected %h actual %h",
                           e.digest_low, m_data.digest_low);
                    error_count++;
                end
                if (m_data.digest_high !== e.digest_high) begin
                    $error("digest_high expected %h actual %h",
                           e.digest_high, m_data.digest_high);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || rx_hold) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic test_directed();
        // empty message, then each tail size and the oversized counts
        send_word(32'h0, 3'd0, 1'b1);
        for (int n = 0; n < 8; n++) send_word(32'hffffffff, n[2:0], 1'b1);
        send_word(32'h00000000, 3'd4, 1'b1);
        // 13 full words and a last word of 3 or 4 bytes: padding fits or needs an extra block
        send_message(13, 3'd3);
        send_message(13, 3'd4);
    endtask

    task automatic test_block_edges();
        // whole blocks and tails around the 56-byte point
        send_message(15, 3'd4);
        send_message(15, 3'd0);
        send_message(16, 3'd0);
        send_message(31, 3'd2);
    endtask

    task automatic test_backpressure();
        // receiver holds off in its own process, counted in cycles
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_LEN) @(posedge aclk);
                rx_hold <= 1'b0;
            end
            for (int m = 0; m < 6; m++)
                send_message($urandom_range(3), 3'($urandom_range(4)));
        join
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 1000) begin
            int len;
            quiet_mode = (sent > 300 && sent < 450);
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(17);
            send_message(len, 3'($urandom_range(7)));
            sent += len + 1;
        end
        quiet_mode = 0;
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        init_hash();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_block_edges();
        test_backpressure();
        test_random();
        s_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
